// ===== rtl/anc_pkg.sv =====
// Shared types, constants and helper functions for the ARP neighbour cache.
// Used by every module of the block but anc_ram; depends on nothing.
package anc_pkg;

  localparam int ENTRIES     = 64;
  localparam int BUCKETS     = 32;
  localparam int HANDLE_BITS = 8;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int BKT_W       = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int MAX_RES     = 64;
  localparam int RES_CNT_W   = $clog2(MAX_RES + 1);
  localparam int PADDR_W     = 4;

  localparam logic [2:0] OP_RESOLVE = 3'd0;
  localparam logic [2:0] OP_ADVERT  = 3'd1;
  localparam logic [2:0] OP_ADD     = 3'd2;
  localparam logic [2:0] OP_DELETE  = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;

  localparam logic [2:0] ST_NONE       = 3'd0;
  localparam logic [2:0] ST_INCOMPLETE = 3'd1;
  localparam logic [2:0] ST_REACHABLE  = 3'd2;
  localparam logic [2:0] ST_STALE      = 3'd3;
  localparam logic [2:0] ST_PROBE      = 3'd4;

  localparam logic [2:0] K_SEND     = 3'd0;
  localparam logic [2:0] K_HELD     = 3'd1;
  localparam logic [2:0] K_DROP     = 3'd2;
  localparam logic [2:0] K_REQ      = 3'd3;
  localparam logic [2:0] K_OK       = 3'd4;
  localparam logic [2:0] K_NOTFOUND = 3'd5;
  localparam logic [2:0] K_FULL     = 3'd6;

  localparam logic [1:0] CFG_REACHABLE  = 2'd0;
  localparam logic [1:0] CFG_RETRANS    = 2'd1;
  localparam logic [1:0] CFG_MAX_PROBES = 2'd2;

  typedef struct packed {
    logic [2:0]             op;
    logic [31:0]            next_hop_ip;
    logic [47:0]            mac_addr;
    logic                   is_advert;
    logic                   solicited;
    logic                   override;
    logic [HANDLE_BITS-1:0] pkt_handle;
  } anc_req_t;

  typedef struct packed {
    logic [2:0]             kind;
    logic [HANDLE_BITS-1:0] pkt_handle_res;
    logic [47:0]            mac_addr_res;
    logic [31:0]            target_ip;
    logic                   last;
  } anc_rsp_t;

  typedef struct packed {
    logic [31:0]            ip;
    logic [47:0]            mac;
    logic [2:0]             state;
    logic                   admin;
    logic [3:0]             probes;
    logic [31:0]            confirmed;
    logic [15:0]            retrans;
    logic                   held_valid;
    logic [HANDLE_BITS-1:0] held_handle;
  } slot_rec_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_SCAN_START,
    CS_SCAN,
    CS_POST1,
    CS_POST2,
    CS_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan;
    logic post1;
    logic post2;
    logic flush;
  } anc_cmd_t;

  typedef struct packed {
    logic step_ok;
    logic scan_end;
    logic post_two;
    logic flush_ok;
  } anc_sts_t;

  function automatic logic [BKT_W-1:0] bucket_of(input logic [31:0] ip);
    logic [31:0] h;
    h = ip;
    h = h ^ (h >> 16);
    h = h ^ (h >> 8);
    h = h ^ (h >> 4);
    return BKT_W'(h % BUCKETS);
  endfunction

  function automatic anc_rsp_t mk_rsp(input logic [2:0] kind,
                                      input logic [HANDLE_BITS-1:0] handle,
                                      input logic [47:0] mac,
                                      input logic [31:0] ip);
    anc_rsp_t r;
    r.kind           = kind;
    r.pkt_handle_res = handle;
    r.mac_addr_res   = mac;
    r.target_ip      = ip;
    r.last           = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/anc_ram.sv =====
// Generic single write port RAM with one registered read port.
// Depends on nothing.
module anc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/anc_ctrl.sv =====
// Controller state machine of the neighbour cache: sequences accept, table scan,
// final update and result flush. Depends on anc_pkg.
module anc_ctrl import anc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  anc_sts_t sts,
  output anc_cmd_t cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: begin
        if (req_valid) state_next = CS_SCAN_START;
      end
      CS_SCAN_START: state_next = CS_SCAN;
      CS_SCAN: begin
        if (sts.step_ok && sts.scan_end) state_next = CS_POST1;
      end
      CS_POST1: begin
        if (sts.step_ok) state_next = sts.post_two ? CS_POST2 : CS_FLUSH;
      end
      CS_POST2: begin
        if (sts.step_ok) state_next = CS_FLUSH;
      end
      CS_FLUSH: begin
        if (sts.flush_ok) state_next = CS_IDLE;
      end
      default: state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    req_ready = 1'b0;
    case (state)
      CS_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      CS_SCAN_START: cmd.scan_start = 1'b1;
      CS_SCAN:       cmd.scan = 1'b1;
      CS_POST1:      cmd.post1 = 1'b1;
      CS_POST2:      cmd.post2 = 1'b1;
      CS_FLUSH:      cmd.flush = 1'b1;
      default:       cmd = '0;
    endcase
  end

endmodule

// ===== rtl/anc_dp.sv =====
// Datapath of the neighbour cache: configuration registers, valid bits, slot scan,
// final slot update and the result staging registers. Depends on anc_pkg.
module anc_dp import anc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  anc_req_t             req_data,
  output anc_rsp_t             rsp_data,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  input  anc_cmd_t             cmd,
  output anc_sts_t             sts,
  output logic                 ram_we,
  output logic [IDX_W-1:0]     ram_waddr,
  output slot_rec_t            ram_wdata,
  output logic [IDX_W-1:0]     ram_raddr,
  input  slot_rec_t            ram_rdata
);

  logic [31:0] reachable_ticks;
  logic [15:0] retrans_ticks;
  logic [3:0]  max_probes;
  logic [31:0] now_ticks;
  logic [ENTRIES-1:0] slot_valid;

  anc_req_t   req_q;
  logic [BKT_W-1:0] req_bkt;
  logic [IDX_W-1:0] cur;
  logic       m_found, f_found;
  logic [IDX_W-1:0] m_idx, f_idx;
  slot_rec_t  m_rec;
  anc_rsp_t   e2_q;
  anc_rsp_t   pend;
  logic       pend_valid;
  logic [RES_CNT_W-1:0] res_cnt;

  logic [15:0] load_val;
  logic        cfg_wr;

  slot_rec_t  s_rec;
  logic       s_v, s_we, s_emit;
  anc_rsp_t   s_item;

  slot_rec_t  p_rec, n_rec;
  logic [IDX_W-1:0] p_idx;
  logic       p_we, p_vset, p_vclr;
  logic       e1v, e2v;
  anc_rsp_t   e1, e2;
  logic [2:0] st;
  logic       same;

  logic       step_active, emit_req, capped, emit_now, can_push, step_ok, go;
  anc_rsp_t   emit_item;

  assign load_val = (retrans_ticks == 16'd0) ? 16'd1 : retrans_ticks;
  assign cfg_wr   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      reachable_ticks <= 32'd30000;
      retrans_ticks   <= 16'd1000;
      max_probes      <= 4'd3;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        CFG_REACHABLE:  reachable_ticks <= pwdata;
        CFG_RETRANS:    retrans_ticks <= pwdata[15:0];
        CFG_MAX_PROBES: max_probes <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      CFG_REACHABLE:  prdata = reachable_ticks;
      CFG_RETRANS:    prdata = {16'd0, retrans_ticks};
      CFG_MAX_PROBES: prdata = {28'd0, max_probes};
      default:        prdata = 32'd0;
    endcase
  end

  assign step_active = cmd.scan || cmd.post1 || cmd.post2;
  assign capped      = (res_cnt == RES_CNT_W'(MAX_RES));
  assign can_push    = !rsp_valid || rsp_ready;

  always_comb begin
    s_rec  = ram_rdata;
    s_v    = slot_valid[cur];
    s_we   = 1'b0;
    s_emit = 1'b0;
    s_item = '0;
    case (req_q.op)
      OP_TICK: begin
        if (slot_valid[cur] && ram_rdata.retrans != 16'd0) begin
          s_we = 1'b1;
          s_rec.retrans = ram_rdata.retrans - 16'd1;
          if (s_rec.retrans == 16'd0 &&
              (ram_rdata.state == ST_INCOMPLETE || ram_rdata.state == ST_PROBE)) begin
            if (ram_rdata.probes >= max_probes) begin
              s_v    = 1'b0;
              s_emit = ram_rdata.held_valid;
              s_item = mk_rsp(K_DROP, ram_rdata.held_handle, 48'd0, 32'd0);
            end else begin
              if (ram_rdata.probes != 4'hF) s_rec.probes = ram_rdata.probes + 4'd1;
              s_rec.retrans = load_val;
              s_emit = 1'b1;
              s_item = mk_rsp(K_REQ, '0, 48'd0, ram_rdata.ip);
            end
          end
        end
      end
      OP_RESOLVE: begin
        if (slot_valid[cur] && bucket_of(ram_rdata.ip) == req_bkt) begin
          s_we = 1'b1;
          if (ram_rdata.state == ST_REACHABLE && !ram_rdata.admin &&
              (now_ticks - ram_rdata.confirmed) > reachable_ticks) begin
            s_rec.state = ST_STALE;
          end
          if (ram_rdata.ip != req_q.next_hop_ip && s_rec.state == ST_STALE) begin
            s_v    = 1'b0;
            s_emit = ram_rdata.held_valid;
            s_item = mk_rsp(K_DROP, ram_rdata.held_handle, 48'd0, 32'd0);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    p_we   = 1'b0;
    p_vset = 1'b0;
    p_vclr = 1'b0;
    p_idx  = m_idx;
    p_rec  = m_rec;
    e1v    = 1'b0;
    e2v    = 1'b0;
    e1     = '0;
    e2     = '0;
    n_rec  = '0;
    n_rec.ip = req_q.next_hop_ip;
    st     = m_rec.state;
    same   = (m_rec.mac == req_q.mac_addr);
    if (m_rec.state == ST_REACHABLE && !m_rec.admin &&
        (now_ticks - m_rec.confirmed) > reachable_ticks) begin
      st = ST_STALE;
    end
    case (req_q.op)
      OP_RESOLVE: begin
        if (m_found) begin
          if (m_rec.state == ST_INCOMPLETE) begin
            p_we = 1'b1;
            p_rec.held_valid  = 1'b1;
            p_rec.held_handle = req_q.pkt_handle;
            e1v = 1'b1;
            if (m_rec.held_valid) begin
              e1  = mk_rsp(K_DROP, m_rec.held_handle, 48'd0, 32'd0);
              e2v = 1'b1;
              e2  = mk_rsp(K_HELD, req_q.pkt_handle, 48'd0, 32'd0);
            end else begin
              e1  = mk_rsp(K_HELD, req_q.pkt_handle, 48'd0, 32'd0);
            end
          end else begin
            e1v = 1'b1;
            e1  = mk_rsp(K_SEND, req_q.pkt_handle, m_rec.mac, 32'd0);
            if (m_rec.state == ST_STALE) begin
              p_we = 1'b1;
              p_rec.state = ST_PROBE;
              if (m_rec.retrans == 16'd0) begin
                if (m_rec.probes != 4'hF) p_rec.probes = m_rec.probes + 4'd1;
                p_rec.retrans = load_val;
                e2v = 1'b1;
                e2  = mk_rsp(K_REQ, '0, 48'd0, m_rec.ip);
              end
            end
          end
        end else if (f_found) begin
          p_idx  = f_idx;
          p_we   = 1'b1;
          p_vset = 1'b1;
          p_rec  = n_rec;
          p_rec.state       = ST_INCOMPLETE;
          p_rec.held_valid  = 1'b1;
          p_rec.held_handle = req_q.pkt_handle;
          p_rec.probes      = 4'd1;
          p_rec.retrans     = load_val;
          e1v = 1'b1;
          e1  = mk_rsp(K_HELD, req_q.pkt_handle, 48'd0, 32'd0);
          e2v = 1'b1;
          e2  = mk_rsp(K_REQ, '0, 48'd0, req_q.next_hop_ip);
        end else begin
          e1v = 1'b1;
          e1  = mk_rsp(K_DROP, req_q.pkt_handle, 48'd0, 32'd0);
        end
      end
      OP_ADVERT: begin
        if (!req_q.mac_addr[40]) begin
          if (!m_found) begin
            if (!req_q.is_advert && f_found) begin
              p_idx  = f_idx;
              p_we   = 1'b1;
              p_vset = 1'b1;
              p_rec  = n_rec;
              p_rec.mac   = req_q.mac_addr;
              p_rec.state = ST_STALE;
            end
          end else begin
            p_we = 1'b1;
            p_rec.state = st;
            if (!req_q.is_advert) begin
              if (st == ST_INCOMPLETE || !same) begin
                p_rec.mac   = req_q.mac_addr;
                p_rec.state = ST_STALE;
              end
              if (st == ST_INCOMPLETE && m_rec.held_valid) begin
                p_rec.held_valid = 1'b0;
                e1v = 1'b1;
                e1  = mk_rsp(K_SEND, m_rec.held_handle, req_q.mac_addr, 32'd0);
              end
            end else if (st == ST_INCOMPLETE) begin
              p_rec.mac = req_q.mac_addr;
              if (m_rec.held_valid) begin
                p_rec.held_valid = 1'b0;
                e1v = 1'b1;
                e1  = mk_rsp(K_SEND, m_rec.held_handle, req_q.mac_addr, 32'd0);
              end
              if (req_q.solicited) begin
                p_rec.state     = ST_REACHABLE;
                p_rec.retrans   = 16'd0;
                p_rec.confirmed = now_ticks;
                p_rec.probes    = 4'd0;
              end else begin
                p_rec.state = ST_STALE;
              end
            end else if (!req_q.override) begin
              if (same) begin
                if (req_q.solicited) begin
                  p_rec.state     = ST_REACHABLE;
                  p_rec.retrans   = 16'd0;
                  p_rec.confirmed = now_ticks;
                  p_rec.probes    = 4'd0;
                end
              end else if (st == ST_REACHABLE) begin
                p_rec.state = ST_STALE;
              end
            end else begin
              p_rec.mac = req_q.mac_addr;
              if (req_q.solicited) begin
                p_rec.state     = ST_REACHABLE;
                p_rec.retrans   = 16'd0;
                p_rec.confirmed = now_ticks;
                p_rec.probes    = 4'd0;
              end else if (!same) begin
                p_rec.state = ST_STALE;
              end
            end
          end
        end
      end
      OP_ADD: begin
        e1v = 1'b1;
        if (m_found) begin
          p_we = 1'b1;
          p_rec.admin = 1'b1;
          e1 = mk_rsp(K_OK, '0, 48'd0, 32'd0);
        end else if (f_found) begin
          p_idx  = f_idx;
          p_we   = 1'b1;
          p_vset = 1'b1;
          p_rec  = n_rec;
          p_rec.admin     = 1'b1;
          p_rec.mac       = req_q.mac_addr;
          p_rec.state     = ST_REACHABLE;
          p_rec.confirmed = now_ticks;
          e1 = mk_rsp(K_OK, '0, 48'd0, 32'd0);
        end else begin
          e1 = mk_rsp(K_FULL, '0, 48'd0, 32'd0);
        end
      end
      OP_DELETE: begin
        e1v = 1'b1;
        if (m_found) begin
          p_vclr = 1'b1;
          if (m_rec.held_valid) begin
            e1  = mk_rsp(K_DROP, m_rec.held_handle, 48'd0, 32'd0);
            e2v = 1'b1;
            e2  = mk_rsp(K_OK, '0, 48'd0, 32'd0);
          end else begin
            e1  = mk_rsp(K_OK, '0, 48'd0, 32'd0);
          end
        end else begin
          e1 = mk_rsp(K_NOTFOUND, '0, 48'd0, 32'd0);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    emit_req  = 1'b0;
    emit_item = '0;
    if (cmd.scan) begin
      emit_req  = s_emit;
      emit_item = s_item;
    end else if (cmd.post1) begin
      emit_req  = e1v;
      emit_item = e1;
    end else if (cmd.post2) begin
      emit_req  = 1'b1;
      emit_item = e2_q;
    end
  end

  assign emit_now = step_active && emit_req && !capped;
  assign step_ok  = !emit_now || !pend_valid || can_push;
  assign go       = step_active && step_ok;

  assign sts.step_ok  = step_ok;
  assign sts.scan_end = (cur == IDX_W'(ENTRIES - 1));
  assign sts.post_two = e2v;
  assign sts.flush_ok = !pend_valid || can_push;

  assign ram_raddr = (cmd.scan && go) ? cur + IDX_W'(1) : (cmd.scan ? cur : '0);
  assign ram_we    = (cmd.scan && go && s_we) || (cmd.post1 && go && p_we);
  assign ram_waddr = cmd.scan ? cur : p_idx;
  assign ram_wdata = cmd.scan ? s_rec : p_rec;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q   <= req_data;
      req_bkt <= bucket_of(req_data.next_hop_ip);
    end
    if (cmd.scan_start) begin
      cur <= '0;
    end else if (cmd.scan && go) begin
      cur <= cur + IDX_W'(1);
    end
    if (cmd.scan && go && !m_found && s_v && s_rec.ip == req_q.next_hop_ip) begin
      m_idx <= cur;
      m_rec <= s_rec;
    end
    if (cmd.scan && go && !f_found && !s_v) begin
      f_idx <= cur;
    end
    if (cmd.post1 && go) begin
      e2_q <= e2;
    end
    if (go && emit_now) begin
      pend <= emit_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ticks  <= 32'd0;
      slot_valid <= '0;
      m_found    <= 1'b0;
      f_found    <= 1'b0;
      pend_valid <= 1'b0;
      res_cnt    <= '0;
    end else begin
      if (cmd.accept) begin
        res_cnt <= '0;
        if (req_data.op == OP_TICK) now_ticks <= now_ticks + 32'd1;
      end
      if (cmd.scan_start) begin
        m_found <= 1'b0;
        f_found <= 1'b0;
      end
      if (cmd.scan && go) begin
        slot_valid[cur] <= s_v;
        if (s_v && s_rec.ip == req_q.next_hop_ip) m_found <= 1'b1;
        if (!s_v) f_found <= 1'b1;
      end
      if (cmd.post1 && go) begin
        if (p_vset) slot_valid[p_idx] <= 1'b1;
        if (p_vclr) slot_valid[p_idx] <= 1'b0;
      end
      if (go && emit_now) begin
        pend_valid <= 1'b1;
        res_cnt    <= res_cnt + RES_CNT_W'(1);
      end else if (cmd.flush && pend_valid && can_push) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((go && emit_now && pend_valid) || (cmd.flush && pend_valid && can_push)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit_now && pend_valid) begin
      rsp_data <= {pend.kind, pend.pkt_handle_res, pend.mac_addr_res, pend.target_ip, 1'b0};
    end else if (cmd.flush && pend_valid && can_push) begin
      rsp_data <= {pend.kind, pend.pkt_handle_res, pend.mac_addr_res, pend.target_ip, 1'b1};
    end
  end

endmodule

// ===== rtl/arp_neighbor_cache_unit.sv =====
// ARP neighbour cache unit: the top level joining controller, datapath and slot RAM.
// Depends on anc_pkg, anc_ram, anc_ctrl and anc_dp.
//
// The block takes one request at a time on the req channel (valid/ready) and
// returns its results on the rsp channel, one result per handshake, with last
// set on the final result of a request. Requests that give no result produce
// nothing on rsp. Each request walks all ENTRIES slots of the table once, one
// slot per cycle through the slot RAM's single read port while no result is
// held up, and then makes the final slot update. The next request is taken
// once the previous one has handed its last result to the output register.
// A result waits in the output register while the receiver stalls; one more
// result is staged behind it, and the scan pauses when both are full.
// Synchronous reset clears the valid bits and the clock count and loads the
// configuration registers with their defaults at once; no clearing pass is needed.
// Configuration registers sit on the APB port at byte addresses 0, 4 and 8.
// The user must write them only while the block is idle; it does not enforce this.
module arp_neighbor_cache_unit import anc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  anc_req_t           req_data,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output anc_rsp_t           rsp_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  anc_cmd_t         cmd;
  anc_sts_t         sts;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  slot_rec_t        ram_wdata, ram_rdata;

  assign pready = 1'b1;

  anc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  anc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .rsp_data  (rsp_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .cmd       (cmd),
    .sts       (sts),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  anc_ram #(
    .WIDTH ($bits(slot_rec_t)),
    .DEPTH (ENTRIES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/anc_checker.sv =====
// Port-level checker for the ARP neighbour cache unit, bound to the top level.
// Depends on anc_pkg and arp_neighbor_cache_unit.
module anc_checker import anc_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_ready,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input anc_rsp_t rsp_data
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.kind <= K_FULL)
    else $error("result kind out of range");

  a_fields_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.kind != K_SEND |-> rsp_data.mac_addr_res == 48'd0)
    else $error("MAC set on a result that sends nothing");

endmodule

bind arp_neighbor_cache_unit anc_checker u_anc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);

// ===== dv/arp_neighbor_cache_unit_tb.sv =====
// Self-checking testbench for the ARP neighbour cache unit: a directed opening,
// a table-fill run and randomised traffic over several register settings.
// Depends on anc_pkg and arp_neighbor_cache_unit.
module arp_neighbor_cache_unit_tb;
  import anc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE = ENTRIES + 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  anc_req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  anc_rsp_t rsp_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  anc_req_t pend_q[$];
  anc_rsp_t exp_q[$];
  int fail_cnt = 0;
  int idle_cnt = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_win = 0;

  logic [31:0] cfg_reach = 32'd30000;
  logic [15:0] cfg_retx = 16'd1000;
  logic [3:0]  cfg_maxp = 4'd3;

  logic        c_valid [ENTRIES];
  logic [31:0] c_ip    [ENTRIES];
  logic [47:0] c_mac   [ENTRIES];
  logic [2:0]  c_st    [ENTRIES];
  logic        c_admin [ENTRIES];
  logic [3:0]  c_probes[ENTRIES];
  logic [31:0] c_conf  [ENTRIES];
  logic [15:0] c_retx  [ENTRIES];
  logic        c_hv    [ENTRIES];
  logic [7:0]  c_hh    [ENTRIES];
  logic [31:0] now_ticks = '0;
  int ev_n;

  logic [31:0] ip_pool[24];
  logic [47:0] mac_pool[4];

  arp_neighbor_cache_unit i_dut (.*);

  always #6 clk = ~clk;

  function automatic logic [4:0] hash_bucket(logic [31:0] ip);
    logic [31:0] h;
    h = ip;
    h = h ^ (h >> 16);
    h = h ^ (h >> 8);
    h = h ^ (h >> 4);
    return 5'(h % BUCKETS);
  endfunction

  function void add_result(logic [2:0] k, logic [7:0] h, logic [47:0] m, logic [31:0] ip);
    anc_rsp_t r;
    if (ev_n < MAX_RES) begin
      r.kind = k;
      r.pkt_handle_res = h;
      r.mac_addr_res = m;
      r.target_ip = ip;
      r.last = 1'b0;
      exp_q.push_back(r);
      ev_n++;
    end
  endfunction

  function void clear_slot(int i);
    c_valid[i] = 1'b0; c_ip[i] = '0; c_mac[i] = '0; c_st[i] = ST_NONE; c_admin[i] = 1'b0;
    c_probes[i] = '0; c_conf[i] = '0; c_retx[i] = '0; c_hv[i] = 1'b0; c_hh[i] = '0;
  endfunction

  function void evict_slot(int i);
    if (c_hv[i]) add_result(K_DROP, c_hh[i], '0, '0);
    clear_slot(i);
  endfunction

  function void enter_state(int i, logic [2:0] s);
    c_st[i] = s;
    if (s == ST_REACHABLE) begin
      c_retx[i] = '0;
      c_conf[i] = now_ticks;
      c_probes[i] = '0;
    end
  endfunction

  function bit expired(int i);
    return !c_admin[i] && (now_ticks - c_conf[i]) > cfg_reach;
  endfunction

  function void send_probe(int i);
    if (c_retx[i] != 0) return;
    if (c_probes[i] != 4'hF) c_probes[i]++;
    c_retx[i] = (cfg_retx == 0) ? 16'd1 : cfg_retx;
    add_result(K_REQ, '0, '0, c_ip[i]);
  endfunction

  function void flush_held(int i);
    if (!c_hv[i]) return;
    add_result(K_SEND, c_hh[i], c_mac[i], '0);
    c_hv[i] = 1'b0;
  endfunction

  function int find_ip(logic [31:0] ip);
    for (int i = 0; i < ENTRIES; i++)
      if (c_valid[i] && c_ip[i] == ip) return i;
    return -1;
  endfunction

  function int alloc_slot(logic [31:0] ip, logic adm, logic [47:0] m);
    for (int i = 0; i < ENTRIES; i++) begin
      if (!c_valid[i]) begin
        clear_slot(i);
        c_valid[i] = 1'b1;
        c_ip[i] = ip;
        c_admin[i] = adm;
        c_mac[i] = m;
        return i;
      end
    end
    return -1;
  endfunction

  function void resolve_next_hop(logic [31:0] ip, logic [7:0] h);
    logic [4:0] b;
    int m;
    b = hash_bucket(ip);
    for (int i = 0; i < ENTRIES; i++) begin
      if (!c_valid[i] || hash_bucket(c_ip[i]) != b) continue;
      if (c_st[i] == ST_REACHABLE && expired(i)) enter_state(i, ST_STALE);
      if (c_ip[i] != ip && c_st[i] == ST_STALE) evict_slot(i);
    end
    m = find_ip(ip);
    if (m >= 0) begin
      if (c_st[m] == ST_INCOMPLETE) begin
        if (c_hv[m]) add_result(K_DROP, c_hh[m], '0, '0);
        c_hv[m] = 1'b1;
        c_hh[m] = h;
        add_result(K_HELD, h, '0, '0);
        return;
      end
      add_result(K_SEND, h, c_mac[m], '0);
      if (c_st[m] == ST_STALE) begin
        enter_state(m, ST_PROBE);
        send_probe(m);
      end
      return;
    end
    m = alloc_slot(ip, 1'b0, '0);
    if (m < 0) begin
      add_result(K_DROP, h, '0, '0);
      return;
    end
    enter_state(m, ST_INCOMPLETE);
    c_hv[m] = 1'b1;
    c_hh[m] = h;
    add_result(K_HELD, h, '0, '0);
    send_probe(m);
  endfunction

  function void learn_neighbour(anc_req_t q);
    int e;
    bit same;
    if (q.mac_addr[40]) return;
    e = find_ip(q.next_hop_ip);
    if (e < 0) begin
      if (!q.is_advert) begin
        e = alloc_slot(q.next_hop_ip, 1'b0, q.mac_addr);
        if (e >= 0) enter_state(e, ST_STALE);
      end
      return;
    end
    same = (c_mac[e] == q.mac_addr);
    if (c_st[e] == ST_REACHABLE && expired(e)) enter_state(e, ST_STALE);
    if (!q.is_advert) begin
      if (c_st[e] == ST_INCOMPLETE) begin
        c_mac[e] = q.mac_addr;
        flush_held(e);
        same = 1'b0;
      end
      if (!same) begin
        c_mac[e] = q.mac_addr;
        enter_state(e, ST_STALE);
      end
    end else if (c_st[e] == ST_INCOMPLETE) begin
      c_mac[e] = q.mac_addr;
      flush_held(e);
      enter_state(e, q.solicited ? ST_REACHABLE : ST_STALE);
    end else if (!q.override) begin
      if (same) begin
        if (q.solicited) enter_state(e, ST_REACHABLE);
      end else if (c_st[e] == ST_REACHABLE) begin
        enter_state(e, ST_STALE);
      end
    end else begin
      c_mac[e] = q.mac_addr;
      if (q.solicited) enter_state(e, ST_REACHABLE);
      else if (!same) enter_state(e, ST_STALE);
    end
  endfunction

  function void advance_tick();
    now_ticks++;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!c_valid[i] || c_retx[i] == 0) continue;
      c_retx[i]--;
      if (c_retx[i] != 0) continue;
      if (c_st[i] == ST_INCOMPLETE || c_st[i] == ST_PROBE) begin
        if (c_probes[i] >= cfg_maxp) evict_slot(i);
        else send_probe(i);
      end
    end
  endfunction

  function void predict_request(anc_req_t q);
    int e;
    ev_n = 0;
    case (q.op)
      OP_RESOLVE: resolve_next_hop(q.next_hop_ip, q.pkt_handle);
      OP_ADVERT: learn_neighbour(q);
      OP_ADD: begin
        e = find_ip(q.next_hop_ip);
        if (e >= 0) begin
          c_admin[e] = 1'b1;
          add_result(K_OK, '0, '0, '0);
        end else begin
          e = alloc_slot(q.next_hop_ip, 1'b1, q.mac_addr);
          if (e < 0) add_result(K_FULL, '0, '0, '0);
          else begin
            enter_state(e, ST_REACHABLE);
            add_result(K_OK, '0, '0, '0);
          end
        end
      end
      OP_DELETE: begin
        e = find_ip(q.next_hop_ip);
        if (e < 0) add_result(K_NOTFOUND, '0, '0, '0);
        else begin
          evict_slot(e);
          add_result(K_OK, '0, '0, '0);
        end
      end
      OP_TICK: advance_tick();
      default: ;
    endcase
    if (ev_n > 0) exp_q[exp_q.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) predict_request(req_data);
      if (!req_valid || req_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          req_valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          req_data <= pend_q.pop_front();
          req_valid <= 1'b1;
          if ($urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 100);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    anc_rsp_t e;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (exp_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result %p", $realtime, rsp_data);
        end else begin
          e = exp_q.pop_front();
          if (rsp_data.kind !== e.kind || rsp_data.pkt_handle_res !== e.pkt_handle_res ||
              rsp_data.mac_addr_res !== e.mac_addr_res ||
              rsp_data.target_ip !== e.target_ip || rsp_data.last !== e.last) begin
            fail_cnt++;
            $display("%0t: mismatch expected %p actual %p", $realtime, e, rsp_data);
          end
        end
      end
      if (stall_win == 0) begin
        stall_win <= $urandom_range(20, 200);
        stall_mode <= $urandom_range(0, 2);
      end else begin
        stall_win <= stall_win - 1;
      end
      case (stall_mode)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= 1'($urandom_range(0, 1));
        default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      CFG_REACHABLE: cfg_reach = val;
      CFG_RETRANS: cfg_retx = val[15:0];
      default: cfg_maxp = val[3:0];
    endcase
  endtask

  task automatic push_req(logic [2:0] op, logic [31:0] ip, logic [47:0] m,
                          logic adv, logic sol, logic ovr, logic [7:0] h);
    anc_req_t q;
    q.op = op;
    q.next_hop_ip = ip;
    q.mac_addr = m;
    q.is_advert = adv;
    q.solicited = sol;
    q.override = ovr;
    q.pkt_handle = h;
    pend_q.push_back(q);
  endtask

  task automatic drain();
    while (pend_q.size() > 0 || req_valid || exp_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_traffic(int n);
    logic [31:0] ip;
    logic [47:0] m;
    int sel;
    for (int k = 0; k < n; k++) begin
      ip = ($urandom_range(0, 15) == 0) ? $urandom() : ip_pool[$urandom_range(0, 23)];
      m = ($urandom_range(0, 9) == 0) ? {16'($urandom()), 32'($urandom())}
                                      : mac_pool[$urandom_range(0, 3)];
      sel = $urandom_range(0, 99);
      if (sel < 30) push_req(OP_RESOLVE, ip, m, 1'($urandom()), 1'($urandom()),
                             1'($urandom()), 8'($urandom()));
      else if (sel < 60) push_req(OP_ADVERT, ip, m, ($urandom_range(0, 3) != 0),
                                  1'($urandom()), 1'($urandom()), 8'($urandom()));
      else if (sel < 67) push_req(OP_ADD, ip, m, 1'($urandom()), 1'($urandom()),
                                  1'($urandom()), 8'($urandom()));
      else if (sel < 74) push_req(OP_DELETE, ip, m, 1'($urandom()), 1'($urandom()),
                                  1'($urandom()), 8'($urandom()));
      else if (sel < 97) push_req(OP_TICK, ip, m, 1'($urandom()), 1'($urandom()),
                                  1'($urandom()), 8'($urandom()));
      else push_req(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), ip, m, 1'($urandom()),
                    1'($urandom()), 1'($urandom()), 8'($urandom()));
    end
  endtask

  initial begin
    logic [31:0] ip;
    logic [31:0] fill_ip[ENTRIES];
    for (int i = 0; i < ENTRIES; i++) clear_slot(i);
    for (int i = 0; i < 24; i++) begin
      ip = $urandom();
      while (hash_bucket(ip) != 5'(i % 6)) ip = $urandom();
      ip_pool[i] = ip;
    end
    for (int i = 0; i < 4; i++) mac_pool[i] = {16'($urandom()), 32'($urandom())} & ~(48'd1 << 40);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    push_req(OP_ADD, 32'hFFFF_FFFF, 48'hFEFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1, 8'hFF);
    push_req(OP_ADD, 32'hFFFF_FFFF, 48'h0, 1'b0, 1'b0, 1'b0, 8'h00);
    push_req(OP_RESOLVE, 32'hFFFF_FFFF, 48'h0, 1'b0, 1'b0, 1'b0, 8'hFF);
    push_req(OP_DELETE, 32'hFFFF_FFFF, 48'h0, 1'b0, 1'b0, 1'b0, 8'h00);
    push_req(OP_DELETE, 32'hFFFF_FFFF, 48'h0, 1'b0, 1'b0, 1'b0, 8'h00);
    push_req(OP_RESOLVE, 32'h0, 48'h0, 1'b0, 1'b0, 1'b0, 8'h00);
    push_req(OP_RESOLVE, 32'h0, 48'h0, 1'b0, 1'b0, 1'b0, 8'h5A);
    push_req(OP_ADVERT, 32'h0, mac_pool[0], 1'b1, 1'b1, 1'b0, 8'h00);
    push_req(OP_RESOLVE, 32'h0, 48'h0, 1'b0, 1'b0, 1'b0, 8'hA5);
    push_req(OP_ADVERT, 32'h0, mac_pool[1], 1'b1, 1'b0, 1'b0, 8'h00);
    push_req(OP_ADVERT, 32'h0, mac_pool[1], 1'b1, 1'b1, 1'b1, 8'h00);
    push_req(OP_ADVERT, ip_pool[0], mac_pool[2], 1'b0, 1'b0, 1'b0, 8'h00);
    push_req(OP_RESOLVE, ip_pool[0], 48'h0, 1'b0, 1'b0, 1'b0, 8'h11);
    push_req(OP_ADVERT, ip_pool[1], 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 8'h00);
    push_req(OP_ADVERT, ip_pool[2], mac_pool[3], 1'b1, 1'b1, 1'b1, 8'h00);
    push_req(OP_RESOLVE, ip_pool[6], 48'h0, 1'b0, 1'b0, 1'b0, 8'h22);
    push_req(OP_ADVERT, ip_pool[6], mac_pool[3], 1'b0, 1'b0, 1'b0, 8'h00);
    push_req(OP_TICK, 32'h0, 48'h0, 1'b0, 1'b0, 1'b0, 8'h00);
    push_req(OP_RSVD_LO, 32'h0, 48'h0, 1'b0, 1'b0, 1'b0, 8'h00);
    push_req(OP_RSVD_HI, 32'h0, 48'h0, 1'b1, 1'b1, 1'b1, 8'hFF);
    random_traffic(30);
    drain();

    cfg_write(CFG_REACHABLE, 32'd1);
    cfg_write(CFG_RETRANS, 32'd1);
    cfg_write(CFG_MAX_PROBES, 32'd1);
    random_traffic(60);
    drain();

    for (int i = 0; i < ENTRIES; i++) begin
      fill_ip[i] = $urandom();
      push_req(OP_ADD, fill_ip[i], mac_pool[i % 4], 1'b0, 1'b0, 1'b0, 8'h00);
    end
    push_req(OP_ADD, 32'h1234_5678, mac_pool[0], 1'b0, 1'b0, 1'b0, 8'h00);
    push_req(OP_RESOLVE, 32'h1234_5678, 48'h0, 1'b0, 1'b0, 1'b0, 8'h77);
    push_req(OP_ADVERT, 32'h1234_5678, mac_pool[0], 1'b0, 1'b0, 1'b0, 8'h00);
    for (int i = 0; i < ENTRIES; i++)
      push_req(OP_DELETE, fill_ip[i], 48'h0, 1'b0, 1'b0, 1'b0, 8'h00);
    drain();

    cfg_write(CFG_REACHABLE, 32'hFFFF_FFFF);
    cfg_write(CFG_RETRANS, 32'd65535);
    cfg_write(CFG_MAX_PROBES, 32'd15);
    random_traffic(40);
    drain();

    cfg_write(CFG_REACHABLE, 32'd4);
    cfg_write(CFG_RETRANS, 32'd2);
    cfg_write(CFG_MAX_PROBES, 32'd2);
    random_traffic(50);
    drain();

    if (fail_cnt == 0 && exp_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/anc_pkg.sv
rtl/anc_ram.sv
rtl/anc_ctrl.sv
rtl/anc_dp.sv
rtl/arp_neighbor_cache_unit.sv
rtl/anc_checker.sv
dv/arp_neighbor_cache_unit_tb.sv
